// ----- hw/rtl/dit_pkg.sv -----
// Shared types and constants for the decimal integer tokenizer.
package dit_pkg;

    localparam logic [7:0]  CH_ZERO   = 8'h30;
    localparam logic [7:0]  CH_NINE   = 8'h39;
    localparam logic [7:0]  CH_MINUS  = 8'h2D;
    localparam logic [7:0]  CH_PLUS   = 8'h2B;
    localparam logic [7:0]  CH_TAB    = 8'h09;
    localparam logic [7:0]  CH_SPACE  = 8'h20;
    localparam logic [34:0] RADIX     = 35'd10;
    localparam logic [30:0] MAG_LIMIT = 31'h7FFF_FFFF;
    localparam int          FIFO_DEPTH = 2;

    typedef enum logic [2:0] {
        CLS_SEP   = 3'd0,
        CLS_DIGIT = 3'd1,
        CLS_MINUS = 3'd2,
        CLS_PLUS  = 3'd3,
        CLS_OTHER = 3'd4,
        CLS_EOS   = 3'd5
    } cls_t;

    typedef enum logic [1:0] {
        KIND_NUMBER = 2'd0,
        KIND_ERROR  = 2'd1,
        KIND_END    = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_SIGN   = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_SKIP   = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_string;
    } item_t;

    typedef struct packed {
        logic signed [31:0] value;
        kind_t              kind;
        logic               last;
    } result_t;

    // classified word passed from front to back
    typedef struct packed {
        cls_t       cls;
        logic [3:0] digit;
    } fe_t;

endpackage

// ----- hw/rtl/dit_front.sv -----
// Front end: input handshake and character classification.
module dit_front (
    input  dit_pkg::item_t item,
    input  logic           item_valid,
    output logic           item_ready,
    input  logic           fifo_full,
    output logic           push,
    output dit_pkg::fe_t   push_data
);
    import dit_pkg::*;

    assign item_ready = !fifo_full;
    assign push       = item_valid && !fifo_full;

    always_comb
    begin
        push_data.digit = 4'(item.char_code - CH_ZERO);
        if (item.end_of_string)
        begin
            push_data.cls = CLS_EOS;
        end
        else if (item.char_code inside {CH_SPACE, CH_TAB})
        begin
            push_data.cls = CLS_SEP;
        end
        else if (item.char_code inside {[CH_ZERO:CH_NINE]})
        begin
            push_data.cls = CLS_DIGIT;
        end
        else if (item.char_code == CH_MINUS)
        begin
            push_data.cls = CLS_MINUS;
        end
        else if (item.char_code == CH_PLUS)
        begin
            push_data.cls = CLS_PLUS;
        end
        else
        begin
            push_data.cls = CLS_OTHER;
        end
    end

endmodule

// ----- hw/rtl/dit_fifo.sv -----
// Short queue of classified words between front and back.
module dit_fifo (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  dit_pkg::fe_t push_data,
    output logic         full,
    input  logic         pop,
    output logic         not_empty,
    output dit_pkg::fe_t pop_data
);
    import dit_pkg::*;

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(FIFO_DEPTH);

    fe_t           mem_reg [FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hw/rtl/dit_back.sv -----
// Back end: token state machine, magnitude accumulator and result register.
module dit_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fifo_not_empty,
    input  dit_pkg::fe_t    fifo_data,
    output logic            pop,
    output logic            result_valid,
    input  logic            result_ready,
    output dit_pkg::result_t result
);
    import dit_pkg::*;

    phase_t      phase_reg, phase_next;
    logic        neg_reg, neg_next;
    logic [30:0] mag_reg, mag_next;
    logic        res_valid_reg, res_valid_next;
    result_t     res_reg, res_next;

    logic        emit;
    logic [30:0] base_mag;
    logic [34:0] acc;
    logic [31:0] cur_value;

    assign pop          = fifo_not_empty && (!res_valid_reg || result_ready);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    assign base_mag  = (phase_reg == PH_IDLE) ? '0 : mag_reg;
    assign acc       = {4'b0, base_mag} * RADIX + {31'b0, fifo_data.digit};
    assign cur_value = neg_reg ? (32'd0 - {1'b0, mag_reg}) : {1'b0, mag_reg};

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        emit       = 1'b0;
        res_next   = res_reg;

        if (pop)
        begin
            case (fifo_data.cls)
                CLS_EOS:
                begin
                    emit           = (phase_reg != PH_SKIP);
                    res_next.last  = 1'b1;
                    res_next.value = (phase_reg == PH_IDLE) ? '0 : cur_value;
                    res_next.kind  = (phase_reg == PH_IDLE) ? KIND_END : KIND_NUMBER;
                    phase_next     = PH_IDLE;
                    neg_next       = 1'b0;
                    mag_next       = '0;
                end
                CLS_SEP:
                begin
                    if (phase_reg == PH_SIGN || phase_reg == PH_DIGITS)
                    begin
                        emit           = 1'b1;
                        res_next.last  = 1'b0;
                        res_next.value = cur_value;
                        res_next.kind  = KIND_NUMBER;
                        phase_next     = PH_IDLE;
                        neg_next       = 1'b0;
                        mag_next       = '0;
                    end
                end
                CLS_DIGIT:
                begin
                    if (phase_reg != PH_SKIP)
                    begin
                        if (acc > {4'b0, MAG_LIMIT})
                        begin
                            emit = 1'b1;
                        end
                        else
                        begin
                            mag_next   = acc[30:0];
                            neg_next   = (phase_reg == PH_IDLE) ? 1'b0 : neg_reg;
                            phase_next = PH_DIGITS;
                        end
                    end
                end
                CLS_MINUS, CLS_PLUS:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        neg_next   = (fifo_data.cls == CLS_MINUS);
                        mag_next   = '0;
                        phase_next = PH_SIGN;
                    end
                    else if (phase_reg != PH_SKIP)
                    begin
                        emit = 1'b1;
                    end
                end
                default:
                begin
                    emit = (phase_reg != PH_SKIP);
                end
            endcase

            // error word: any emit outside end mark and separator handling
            if (emit && fifo_data.cls != CLS_EOS && fifo_data.cls != CLS_SEP)
            begin
                res_next.value = '0;
                res_next.kind  = KIND_ERROR;
                res_next.last  = 1'b1;
                phase_next     = PH_SKIP;
                neg_next       = 1'b0;
                mag_next       = '0;
            end
        end
    end

    always_comb
    begin
        if (pop)
        begin
            res_valid_next = emit;
        end
        else if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            neg_reg       <= 1'b0;
            mag_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            mag_reg       <= mag_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// ----- hw/rtl/decimal_integer_tokenizer.sv -----
// Decimal integer tokenizer: front classifier, word queue, back accumulator.
// Latency: an accepted word is written into the queue; the back end pops it once the
// result register is free or being taken, and its result is registered there.
// Throughput: one word per cycle unless a waiting result stalls it; the accumulator update is one times-ten add.
// The two-entry queue absorbs two words while a result waits, then input stalls.
// Reset clears the token state, the queue pointers and the result valid flag.
module decimal_integer_tokenizer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  dit_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output dit_pkg::result_t result
);
    import dit_pkg::*;

    logic push, pop, fifo_full, fifo_not_empty;
    fe_t  push_data, pop_data;

    dit_front u_front (
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .fifo_full  (fifo_full),
        .push       (push),
        .push_data  (push_data)
    );

    dit_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (pop),
        .not_empty (fifo_not_empty),
        .pop_data  (pop_data)
    );

    dit_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .fifo_not_empty (fifo_not_empty),
        .fifo_data      (pop_data),
        .pop            (pop),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result         (result)
    );

endmodule

// ----- bench/decimal_integer_tokenizer_tb.sv -----
// Self-checking testbench for the decimal integer tokenizer: directed and random strings, random stalls.
module decimal_integer_tokenizer_tb;
    import dit_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_WORDS = 1730;
    localparam int HOLD_SPACING = 400;

    typedef struct {
        item_t word;
        bit    drain;
    } feed_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_ready;
    item_t   item = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    feed_t   chars_to_send[$];
    result_t tokens_due[$];

    // parser state mirrored by the predictor
    phase_t      tok_phase = PH_IDLE;
    logic        tok_neg = 1'b0;
    logic [30:0] tok_mag = '0;

    bit      hold_next = 1'b0;
    int      idle_left = 0;
    int      stall_left = 0;
    int      tx_calm = 0;
    int      rx_calm = 0;
    int      cycles = 0;
    int      failures = 0;
    int      strings_sent = 0;
    int      words_in = 0;
    int      numbers_seen = 0;
    int      errors_seen = 0;
    int      ends_seen = 0;
    result_t predicted;
    result_t oldest;

    decimal_integer_tokenizer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #2 clk = ~clk;

    // Returns 1 when the word produces a result, placed in r.
    function automatic logic parse_char(input item_t w, output result_t r);
        logic [34:0]        acc;
        logic signed [31:0] signed_val;
        logic               emit;
        logic               bad;
        signed_val = {1'b0, tok_mag};
        if (tok_neg)
            signed_val = -signed_val;
        r = '{value: 32'sd0, kind: KIND_NUMBER, last: 1'b0};
        emit = 1'b0;
        bad = 1'b0;
        if (w.end_of_string)
        begin
            if (tok_phase == PH_IDLE)
            begin
                r.kind = KIND_END;
                r.last = 1'b1;
                emit = 1'b1;
            end
            else if (tok_phase != PH_SKIP)
            begin
                r.value = signed_val;
                r.last = 1'b1;
                emit = 1'b1;
            end
            tok_phase = PH_IDLE;
            tok_neg = 1'b0;
            tok_mag = '0;
        end
        else if (tok_phase == PH_SKIP)
        begin
            emit = 1'b0;
        end
        else if (w.char_code == CH_SPACE || w.char_code == CH_TAB)
        begin
            if (tok_phase != PH_IDLE)
            begin
                r.value = signed_val;
                emit = 1'b1;
                tok_phase = PH_IDLE;
                tok_neg = 1'b0;
                tok_mag = '0;
            end
        end
        else if (w.char_code >= CH_ZERO && w.char_code <= CH_NINE)
        begin
            if (tok_phase == PH_IDLE)
            begin
                tok_neg = 1'b0;
                tok_mag = '0;
            end
            acc = {4'd0, tok_mag} * 35'd10 + {31'd0, w.char_code[3:0]};
            if (acc > {4'd0, MAG_LIMIT})
            begin
                bad = 1'b1;
            end
            else
            begin
                tok_mag = acc[30:0];
                tok_phase = PH_DIGITS;
            end
        end
        else if (w.char_code == CH_MINUS || w.char_code == CH_PLUS)
        begin
            if (tok_phase != PH_IDLE)
            begin
                bad = 1'b1;
            end
            else
            begin
                tok_neg = (w.char_code == CH_MINUS);
                tok_mag = '0;
                tok_phase = PH_SIGN;
            end
        end
        else
        begin
            bad = 1'b1;
        end
        if (bad)
        begin
            r = '{value: 32'sd0, kind: KIND_ERROR, last: 1'b1};
            emit = 1'b1;
            tok_phase = PH_SKIP;
            tok_neg = 1'b0;
            tok_mag = '0;
        end
        return emit;
    endfunction

    // Mostly zero, sometimes short, rarely long; calm runs give gap-free stretches.
    function automatic int pause_len(inout int calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if (r < 3)
            calm = $urandom_range(20, 80);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void note_field(string name, longint want, longint got);
        if (want != got)
        begin
            failures++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    function automatic logic [7:0] sep_char();
        return $urandom_range(0, 1) ? CH_TAB : CH_SPACE;
    endfunction

    function automatic logic [7:0] noise_char();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0)
            return CH_MINUS;
        if (r == 1)
            return CH_PLUS;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic add_word(input logic [7:0] c, input logic eos);
        feed_t f;
        f.word.char_code = c;
        f.word.end_of_string = eos;
        f.drain = hold_next;
        hold_next = 1'b0;
        chars_to_send.push_back(f);
        if (eos)
            strings_sent++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_word(s[i], 1'b0);
    endtask

    task automatic add_random_string();
        int              ntok;
        int              r;
        longint unsigned mag;
        ntok = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0)
            add_word(sep_char(), 1'b0);
        for (int k = 0; k < ntok; k++)
        begin
            if (k > 0)
                repeat ($urandom_range(1, 2)) add_word(sep_char(), 1'b0);
            case ($urandom_range(0, 3))
                0: add_word(CH_MINUS, 1'b0);
                1: add_word(CH_PLUS, 1'b0);
                default: ;
            endcase
            r = $urandom_range(0, 99);
            if (r >= 5)
            begin
                if (r < 45)
                begin
                    mag = $urandom_range(0, 999);
                end
                else if (r < 60)
                begin
                    mag = $urandom();
                end
                else if (r < 78)
                begin
                    // straddle the largest legal magnitude
                    mag = 64'd2147483644 + $urandom_range(0, 6);
                end
                else if (r < 85)
                begin
                    mag = {$urandom(), $urandom()} % 64'd100000000000;
                end
                else
                begin
                    repeat ($urandom_range(1, 3)) add_word(CH_ZERO, 1'b0);
                    mag = $urandom_range(0, 99999);
                end
                add_text($sformatf("%0d", mag));
            end
            if ($urandom_range(0, 99) < 8)
                add_word(noise_char(), 1'b0);
        end
        if ($urandom_range(0, 3) == 0)
            add_word(sep_char(), 1'b0);
        add_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // driver: predicts each accepted word, then offers the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
            idle_left = 0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                words_in++;
                if (parse_char(item, predicted))
                    tokens_due.push_back(predicted);
            end
            if (item_valid && !item_ready)
            begin
                // hold the word until taken
            end
            else if (idle_left > 0)
            begin
                idle_left--;
                item_valid <= 1'b0;
            end
            else if (chars_to_send.size() > 0 && (!chars_to_send[0].drain ||
                     (tokens_due.size() == 0 && !result_valid)))
            begin
                item <= chars_to_send[0].word;
                item_valid <= 1'b1;
                chars_to_send.pop_front();
                idle_left = pause_len(tx_calm);
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each accepted result against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (tokens_due.size() == 0)
                begin
                    failures++;
                    $display("%0t: unexpected result, expected none, %s %0d kind %0d last %0b",
                             $time, "got value", result.value, result.kind, result.last);
                end
                else
                begin
                    oldest = tokens_due.pop_front();
                    note_field("value", oldest.value, result.value);
                    note_field("kind", oldest.kind, result.kind);
                    note_field("last", oldest.last, result.last);
                    case (oldest.kind)
                        KIND_NUMBER: numbers_seen++;
                        KIND_ERROR:  errors_seen++;
                        default:     ends_seen++;
                    endcase
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
                stall_left = pause_len(rx_calm);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, tokens_due.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        int next_hold;
        int directed_len;

        // end mark alone
        add_word(8'h41, 1'b1);
        // lone plus before a space, lone minus before the end mark
        add_word(CH_PLUS, 1'b0);
        add_word(CH_SPACE, 1'b0);
        add_word(CH_MINUS, 1'b0);
        add_word(8'h00, 1'b1);
        // leading tab, sign after a digit, end mark while skipping
        add_word(CH_TAB, 1'b0);
        add_word(CH_NINE, 1'b0);
        add_word(CH_MINUS, 1'b0);
        add_word(8'hFF, 1'b1);
        // sign after a sign
        add_word(CH_MINUS, 1'b0);
        add_word(CH_PLUS, 1'b0);
        add_word(8'h00, 1'b1);
        // NUL without the end mark, then a skipped word
        add_word(8'h00, 1'b0);
        add_word(8'hFF, 1'b0);
        add_word(8'h80, 1'b1);
        // separator after a token, then end mark between tokens
        add_word(8'h31, 1'b0);
        add_word(CH_SPACE, 1'b0);
        add_word(8'h7F, 1'b1);
        // zero closed by the end mark
        add_word(CH_ZERO, 1'b0);
        add_word(8'h55, 1'b1);

        directed_len = chars_to_send.size();
        next_hold = directed_len + HOLD_SPACING;
        while (chars_to_send.size() < directed_len + RANDOM_WORDS)
        begin
            if (chars_to_send.size() >= next_hold)
            begin
                hold_next = 1'b1;
                next_hold += HOLD_SPACING;
            end
            add_random_string();
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (chars_to_send.size() > 0 || item_valid)
            @(posedge clk);
        while (tokens_due.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("%0d words in %0d strings sent; checked %0d numbers, %0d errors, %0d empty ends",
                 words_in, strings_sent, numbers_seen, errors_seen, ends_seen);
        if (failures == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- decimal_integer_tokenizer.f -----
hw/rtl/dit_pkg.sv
hw/rtl/dit_front.sv
hw/rtl/dit_fifo.sv
hw/rtl/dit_back.sv
hw/rtl/decimal_integer_tokenizer.sv
bench/decimal_integer_tokenizer_tb.sv
